// ----- rtl/core/fhd_pkg.sv -----
// fhd_pkg: shared types and codes of the frame header deframer
`timescale 1ns / 1ps
`default_nettype none
package fhd_pkg;

   // result kinds
   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   // error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_BAD_TYPE  = 3'd1;
   localparam logic [2:0] ERR_TOO_LONG  = 3'd2;
   localparam logic [2:0] ERR_BAD_SUM   = 3'd3;
   localparam logic [2:0] ERR_SHORT_HDR = 3'd4;
   localparam logic [2:0] ERR_SHORT_PAY = 3'd5;

   // parser phases
   localparam logic [2:0] PH_HDR0 = 3'd0;
   localparam logic [2:0] PH_HDR1 = 3'd1;
   localparam logic [2:0] PH_HDR2 = 3'd2;
   localparam logic [2:0] PH_HDR3 = 3'd3;
   localparam logic [2:0] PH_PAY  = 3'd4;
   localparam logic [2:0] PH_DROP = 3'd5;

   // register indexes (byte address / 4)
   localparam logic [1:0] REG_TYPE_A    = 2'd0;
   localparam logic [1:0] REG_TYPE_B    = 2'd1;
   localparam logic [1:0] REG_TYPE_C    = 2'd2;
   localparam logic [1:0] REG_LEN_LIMIT = 2'd3;

   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   // input transaction payload
   typedef struct packed {
      logic [7:0] data_byte;
      logic       buffer_end;
   } req_payload_type;

   // result transaction payload
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  frame_flags;
      logic [15:0] payload_length;
      logic [7:0]  payload_byte;
      logic [2:0]  error_code;
      logic        frame_last;
   } rsp_payload_type;

endpackage
`default_nettype wire

// ----- rtl/core/fhd_channels.sv -----
// fhd_channels: valid/ready channel interfaces for input bytes and results
`timescale 1ns / 1ps
`default_nettype none
interface fhd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       buffer_end;

   modport source (output valid, output data_byte, output buffer_end, input ready);
   modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface fhd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  frame_flags;
   logic [15:0] payload_length;
   logic [7:0]  payload_byte;
   logic [2:0]  error_code;
   logic        frame_last;

   modport source (output valid, output kind, output frame_flags, output payload_length,
                   output payload_byte, output error_code, output frame_last, input ready);
   modport sink   (input valid, input kind, input frame_flags, input payload_length,
                   input payload_byte, input error_code, input frame_last, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/frame_header_deframer_core.sv -----
// frame_header_deframer_core: checks a 4-byte frame header and passes the payload through
// path: an accepted byte is held in the input register, then its result goes to the result register
// throughput: one byte per cycle while results are taken, set by the single parse stage
//   between the input and result registers; bytes that give no result never stall it
// reset: synchronous, active high; clears valids and parser state, and sets the
//   type codes to 1, 2, 3 and the length limit to 4096
`timescale 1ns / 1ps
`default_nettype none
module frame_header_deframer_core
   import fhd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   fhd_req_if.sink                    req_if,
   fhd_rsp_if.source                  rsp_if,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   // configuration registers
   logic [3:0]  type_a_ff, type_b_ff, type_c_ff;
   logic [15:0] len_limit_ff;
   logic        csr_wr;
   logic [1:0]  csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         type_a_ff    <= 4'd1;
         type_b_ff    <= 4'd2;
         type_c_ff    <= 4'd3;
         len_limit_ff <= 16'd4096;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_TYPE_A:    type_a_ff    <= pwdata[3:0];
            REG_TYPE_B:    type_b_ff    <= pwdata[3:0];
            REG_TYPE_C:    type_c_ff    <= pwdata[3:0];
            REG_LEN_LIMIT: len_limit_ff <= pwdata[15:0];
            default:       len_limit_ff <= len_limit_ff;
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (csr_idx)
         REG_TYPE_A:    prdata = {28'd0, type_a_ff};
         REG_TYPE_B:    prdata = {28'd0, type_b_ff};
         REG_TYPE_C:    prdata = {28'd0, type_c_ff};
         REG_LEN_LIMIT: prdata = {16'd0, len_limit_ff};
         default:       prdata = '0;
      endcase
   end

   // input register
   logic            stg_valid_ff, stg_valid_in;
   req_payload_type stg_ff;
   logic            stg_adv;
   logic            out_free;
   logic            res_valid;
   logic            req_take;

   // result register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, res;

   // parser state
   logic [2:0]  phase_ff, phase_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  flags_ff, flags_in;
   logic [15:0] length_ff, length_in;
   logic [7:0]  sum_ff, sum_in;

   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign stg_adv      = stg_valid_ff && (out_free || !res_valid);
   assign req_if.ready = !stg_valid_ff || stg_adv;
   assign req_take     = req_if.valid && req_if.ready;
   assign stg_valid_in = req_take || (stg_valid_ff && !stg_adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stg_ff.data_byte  <= req_if.data_byte;
         stg_ff.buffer_end <= req_if.buffer_end;
      end
   end

   // parse one byte against the current phase
   logic [7:0]  b;
   logic        b_end;
   logic [3:0]  tnib;
   logic        type_ok;
   logic [2:0]  hdr_err;
   logic [15:0] count_inc;
   logic [1:0]  r_kind;
   logic [7:0]  r_pb;
   logic [2:0]  r_err;
   logic        r_last;

   always_comb begin
      b         = stg_ff.data_byte;
      b_end     = stg_ff.buffer_end;
      tnib      = flags_ff[7:4];
      type_ok   = (tnib == type_a_ff) || (tnib == type_b_ff) || (tnib == type_c_ff);
      count_inc = count_ff + 16'd1;
      phase_in  = phase_ff;
      count_in  = count_ff;
      flags_in  = flags_ff;
      length_in = length_ff;
      sum_in    = sum_ff;
      res_valid = 1'b0;
      r_kind    = KIND_HEADER;
      r_pb      = 8'd0;
      r_err     = ERR_NONE;
      r_last    = 1'b0;

      // header check order: type, then length, then checksum
      priority if (!type_ok)                hdr_err = ERR_BAD_TYPE;
      else if (length_ff >= len_limit_ff)   hdr_err = ERR_TOO_LONG;
      else if (b != sum_ff)                 hdr_err = ERR_BAD_SUM;
      else                                  hdr_err = ERR_NONE;

      unique case (phase_ff)
         PH_HDR0: begin
            flags_in  = b;
            length_in = 16'd0;
            sum_in    = b;
            count_in  = 16'd0;
            phase_in  = PH_HDR1;
         end
         PH_HDR1: begin
            length_in = {8'd0, b};
            sum_in    = sum_ff + b;
            phase_in  = PH_HDR2;
         end
         PH_HDR2: begin
            length_in = {b, length_ff[7:0]};
            sum_in    = sum_ff + b;
            phase_in  = PH_HDR3;
         end
         PH_HDR3: begin
            res_valid = 1'b1;
            r_last    = 1'b1;
            phase_in  = PH_DROP;
            priority if (hdr_err != ERR_NONE) begin
               r_kind = KIND_ERROR;
               r_err  = hdr_err;
            end else if (length_ff == 16'd0) begin
               r_kind = KIND_HEADER;
            end else if (b_end) begin
               r_kind = KIND_ERROR;
               r_err  = ERR_SHORT_PAY;
            end else begin
               r_kind   = KIND_HEADER;
               r_last   = 1'b0;
               count_in = 16'd0;
               phase_in = PH_PAY;
            end
         end
         PH_PAY: begin
            res_valid = 1'b1;
            count_in  = count_inc;
            priority if (count_inc == length_ff) begin
               r_kind   = KIND_PAYLOAD;
               r_pb     = b;
               r_last   = 1'b1;
               phase_in = PH_DROP;
            end else if (b_end) begin
               r_kind   = KIND_ERROR;
               r_err    = ERR_SHORT_PAY;
               r_last   = 1'b1;
               phase_in = PH_DROP;
            end else begin
               r_kind = KIND_PAYLOAD;
               r_pb   = b;
            end
         end
         default: begin
            phase_in = PH_DROP;
         end
      endcase

      // buffer ends inside the header
      if (b_end && (phase_ff == PH_HDR0 || phase_ff == PH_HDR1 || phase_ff == PH_HDR2)) begin
         res_valid = 1'b1;
         r_kind    = KIND_ERROR;
         r_err     = ERR_SHORT_HDR;
         r_last    = 1'b1;
      end
      // end of buffer always restarts the parser
      if (b_end) begin
         phase_in = PH_HDR0;
         count_in = 16'd0;
         sum_in   = 8'd0;
      end

      res.kind           = r_kind;
      res.frame_flags    = flags_in;
      res.payload_length = length_in;
      res.payload_byte   = r_pb;
      res.error_code     = r_err;
      res.frame_last     = r_last;
   end

   // parser state update
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         count_ff  <= 16'd0;
         flags_ff  <= 8'd0;
         length_ff <= 16'd0;
         sum_ff    <= 8'd0;
      end else if (stg_adv) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         flags_ff  <= flags_in;
         length_ff <= length_in;
         sum_ff    <= sum_in;
      end
   end

   // result register
   assign rsp_valid_in = (stg_adv && res_valid) || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stg_adv && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.kind           = rsp_ff.kind;
   assign rsp_if.frame_flags    = rsp_ff.frame_flags;
   assign rsp_if.payload_length = rsp_ff.payload_length;
   assign rsp_if.payload_byte   = rsp_ff.payload_byte;
   assign rsp_if.error_code     = rsp_ff.error_code;
   assign rsp_if.frame_last     = rsp_ff.frame_last;

   // a byte with the buffer end flag sends the parser back to header byte zero
   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      (stg_adv && stg_ff.buffer_end) |=> (phase_ff == PH_HDR0))
      else $error("parser did not restart after buffer end");

   // error results always close the frame
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind == KIND_ERROR) |-> (rsp_ff.frame_last && rsp_ff.error_code != ERR_NONE))
      else $error("error result without frame end or code");

   // non-error results carry no error code
   a_no_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind != KIND_ERROR) |-> (rsp_ff.error_code == ERR_NONE))
      else $error("error code on a non-error result");

   // a stalled input byte is never lost when the result side is blocked
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (stg_valid_ff && !stg_adv) |=> (stg_valid_ff && $stable(stg_ff)))
      else $error("stalled input byte changed");

   // payload phase counts stay below the header length
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAY) |-> (count_ff < length_ff))
      else $error("payload count overran header length");

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
// testbench: self-checking testbench for frame_header_deframer_core with its own deframing predictor
`timescale 1ns / 1ps
module testbench;
   import fhd_pkg::*;

   typedef logic [7:0] octet_queue[$];

   logic clock = 1'b0;
   logic reset;

   // configuration port
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   fhd_req_if req_chan();
   fhd_rsp_if rsp_chan();

   frame_header_deframer_core uut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_chan),
      .rsp_if  (rsp_chan),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // predictor state and its copy of the registers
   logic [2:0]  parse_phase = PH_HDR0;
   logic [15:0] pay_count   = '0;
   logic [7:0]  hold_flags  = '0;
   logic [15:0] hold_length = '0;
   logic [7:0]  hold_sum    = '0;
   logic [3:0]  code_a      = 4'd1;
   logic [3:0]  code_b      = 4'd2;
   logic [3:0]  code_c      = 4'd3;
   logic [15:0] len_limit   = 16'd4096;

   rsp_payload_type pending_results[$];

   int  error_count      = 0;
   int  bytes_sent       = 0;
   int  results_checked  = 0;
   int  settings_applied = 0;
   logic idle_enable     = 1'b1;

   always #10 clock = ~clock;

   // mismatch reporting
   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= 100) $display("mismatch at %0t: %s", $time, what);
   endtask

   function automatic rsp_payload_type shape_result(input logic [1:0] kind,
                                                    input logic [7:0] pay_byte,
                                                    input logic [2:0] err,
                                                    input logic last_flag);
      rsp_payload_type r;
      r.kind           = kind;
      r.frame_flags    = hold_flags;
      r.payload_length = hold_length;
      r.payload_byte   = pay_byte;
      r.error_code     = err;
      r.frame_last     = last_flag;
      return r;
   endfunction

   // deframing predictor: one accepted byte, zero or one result
   task automatic predict_deframe(input logic [7:0] b, input logic last_in);
      logic [2:0]      next_phase;
      logic [2:0]      err;
      logic            produced;
      rsp_payload_type r;
      next_phase = parse_phase;
      produced   = 1'b0;
      r          = '0;
      case (parse_phase)
         PH_HDR0: begin
            hold_flags  = b;
            hold_length = '0;
            hold_sum    = b;
            pay_count   = '0;
            next_phase  = PH_HDR1;
         end
         PH_HDR1: begin
            hold_length = {8'h00, b};
            hold_sum    = hold_sum + b;
            next_phase  = PH_HDR2;
         end
         PH_HDR2: begin
            hold_length[15:8] = b;
            hold_sum          = hold_sum + b;
            next_phase        = PH_HDR3;
         end
         PH_HDR3: begin
            // type first, then length, then checksum
            err = ERR_NONE;
            if (hold_flags[7:4] != code_a && hold_flags[7:4] != code_b &&
                hold_flags[7:4] != code_c)
               err = ERR_BAD_TYPE;
            else if (hold_length >= len_limit)
               err = ERR_TOO_LONG;
            else if (b != hold_sum)
               err = ERR_BAD_SUM;
            if (err != ERR_NONE) begin
               r = shape_result(KIND_ERROR, 8'h00, err, 1'b1);
               next_phase = PH_DROP;
            end else if (hold_length == 16'd0) begin
               r = shape_result(KIND_HEADER, 8'h00, ERR_NONE, 1'b1);
               next_phase = PH_DROP;
            end else if (last_in) begin
               r = shape_result(KIND_ERROR, 8'h00, ERR_SHORT_PAY, 1'b1);
               next_phase = PH_DROP;
            end else begin
               r = shape_result(KIND_HEADER, 8'h00, ERR_NONE, 1'b0);
               pay_count  = '0;
               next_phase = PH_PAY;
            end
            produced = 1'b1;
         end
         PH_PAY: begin
            pay_count = pay_count + 16'd1;
            if (pay_count == hold_length) begin
               r = shape_result(KIND_PAYLOAD, b, ERR_NONE, 1'b1);
               next_phase = PH_DROP;
            end else if (last_in) begin
               r = shape_result(KIND_ERROR, 8'h00, ERR_SHORT_PAY, 1'b1);
               next_phase = PH_DROP;
            end else begin
               r = shape_result(KIND_PAYLOAD, b, ERR_NONE, 1'b0);
            end
            produced = 1'b1;
         end
         default: next_phase = PH_DROP;
      endcase
      // buffer ended inside the header
      if (last_in && (parse_phase == PH_HDR0 || parse_phase == PH_HDR1 ||
                      parse_phase == PH_HDR2)) begin
         r = shape_result(KIND_ERROR, 8'h00, ERR_SHORT_HDR, 1'b1);
         produced = 1'b1;
      end
      if (last_in) begin
         next_phase = PH_HDR0;
         pay_count  = '0;
         hold_sum   = '0;
      end
      parse_phase = next_phase;
      if (produced) pending_results.push_back(r);
   endtask

   // send one input transaction, with an optional idle burst first
   task automatic send_byte(input logic [7:0] b, input logic last_in);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.data_byte  <= b;
      req_chan.buffer_end <= last_in;
      @(negedge clock);
      while (!req_chan.ready) @(negedge clock);
      @(posedge clock);
      predict_deframe(b, last_in);
      bytes_sent++;
   endtask

   task automatic send_buffer(input octet_queue bytes);
      int i;
      for (i = 0; i < bytes.size(); i++) send_byte(bytes[i], i == bytes.size() - 1);
   endtask

   function automatic octet_queue build_header(input logic [7:0] flags,
                                               input logic [15:0] length,
                                               input logic [7:0] sum_skew);
      octet_queue hdr;
      logic [7:0] sum;
      sum = flags + length[7:0] + length[15:8] + sum_skew;
      hdr.push_back(flags);
      hdr.push_back(length[7:0]);
      hdr.push_back(length[15:8]);
      hdr.push_back(sum);
      return hdr;
   endfunction

   // result checker: a transaction is taken at the edge after this sample
   task automatic check_result();
      rsp_payload_type got;
      rsp_payload_type want;
      got.kind           = rsp_chan.kind;
      got.frame_flags    = rsp_chan.frame_flags;
      got.payload_length = rsp_chan.payload_length;
      got.payload_byte   = rsp_chan.payload_byte;
      got.error_code     = rsp_chan.error_code;
      got.frame_last     = rsp_chan.frame_last;
      if (pending_results.size() == 0) begin
         report_mismatch($sformatf("result with nothing expected, kind %0d", got.kind));
      end else begin
         want = pending_results.pop_front();
         results_checked++;
         if (got.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
         if (got.frame_flags !== want.frame_flags)
            report_mismatch($sformatf("frame_flags %h, expected %h",
                                      got.frame_flags, want.frame_flags));
         if (got.payload_length !== want.payload_length)
            report_mismatch($sformatf("payload_length %0d, expected %0d",
                                      got.payload_length, want.payload_length));
         if (got.payload_byte !== want.payload_byte)
            report_mismatch($sformatf("payload_byte %h, expected %h",
                                      got.payload_byte, want.payload_byte));
         if (got.error_code !== want.error_code)
            report_mismatch($sformatf("error_code %0d, expected %0d",
                                      got.error_code, want.error_code));
         if (got.frame_last !== want.frame_last)
            report_mismatch($sformatf("frame_last %0d, expected %0d",
                                      got.frame_last, want.frame_last));
      end
   endtask

   initial begin
      forever begin
         @(negedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) check_result();
      end
   end

   // result side stalls in random bursts
   initial begin
      rsp_chan.ready = 1'b1;
      forever begin
         @(posedge clock);
         if (idle_enable && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
      end
   end

   // apb access: setup cycle, then access cycle
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      while (!pready) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic csr_read_check(input logic [1:0] idx, input logic [31:0] want);
      logic [31:0] got;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      while (!pready) @(negedge clock);
      got = prdata;
      @(posedge clock);
      if (got !== want)
         report_mismatch($sformatf("register %0d reads %h, expected %h", idx, got, want));
   endtask

   // drain all expected results plus the pipeline before touching registers
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_setting(input logic [3:0] a, input logic [3:0] b,
                                input logic [3:0] c, input logic [15:0] limit);
      wait_idle();
      csr_write(REG_TYPE_A, {28'd0, a});
      csr_write(REG_TYPE_B, {28'd0, b});
      csr_write(REG_TYPE_C, {28'd0, c});
      csr_write(REG_LEN_LIMIT, {16'd0, limit});
      code_a    = a;
      code_b    = b;
      code_c    = c;
      len_limit = limit;
      csr_read_check(REG_TYPE_A, {28'd0, a});
      csr_read_check(REG_TYPE_B, {28'd0, b});
      csr_read_check(REG_TYPE_C, {28'd0, c});
      csr_read_check(REG_LEN_LIMIT, {16'd0, limit});
      psel    <= 1'b0;
      penable <= 1'b0;
      settings_applied++;
   endtask

   // header checks, check order and early buffer ends at reset settings
   task automatic test_directed_frames();
      octet_queue q;
      q = build_header(8'h1F, 16'd1, 8'h00);
      q.push_back(8'hFF);
      send_buffer(q);
      send_buffer(build_header(8'h3A, 16'd0, 8'h00));
      // bad type wins over too long and bad checksum
      send_buffer(build_header(8'hF0, 16'd5000, 8'h01));
      // too long wins over bad checksum
      send_buffer(build_header(8'h25, 16'd4096, 8'h02));
      send_buffer(build_header(8'h1C, 16'd3, 8'h01));
      // buffer ends inside the header
      q = '{};
      q.push_back(8'h20);
      send_buffer(q);
      q.push_back(8'h02);
      send_buffer(q);
      q.push_back(8'h01);
      send_buffer(q);
      // buffer ends on the checksum, then inside the payload
      send_buffer(build_header(8'h31, 16'd3, 8'h00));
      q = build_header(8'h11, 16'd2, 8'h00);
      q.push_back(8'h00);
      send_buffer(q);
   endtask

   // register extremes, zero limit and the largest lengths
   task automatic test_register_extremes();
      octet_queue q;
      int i;
      apply_setting(4'd0, 4'd15, 4'd0, 16'd0);
      send_buffer(build_header(8'h0F, 16'd0, 8'h00));
      apply_setting(4'd15, 4'd0, 4'd15, 16'd1);
      send_buffer(build_header(8'hF7, 16'd0, 8'h00));
      q = build_header(8'h07, 16'd1, 8'h00);
      q.push_back(8'hAA);
      send_buffer(q);
      apply_setting(4'd0, 4'd15, 4'd0, 16'd65535);
      q = build_header(8'h05, 16'd65534, 8'h00);
      q.push_back(8'h5A);
      q.push_back(8'hA5);
      send_buffer(q);
      send_buffer(build_header(8'hF0, 16'd65535, 8'h00));
      // a full frame long enough to carry the payload count past one byte
      q = build_header(8'hF3, 16'd300, 8'h00);
      for (i = 0; i < 302; i++) q.push_back(8'($urandom_range(0, 255)));
      send_buffer(q);
   endtask

   // one random buffer: mostly well formed frames, the rest broken or noise
   task automatic send_random_buffer();
      octet_queue q;
      int          variant;
      int          i;
      int          cut;
      logic [3:0]  nib;
      logic [15:0] length;
      logic [15:0] cap;
      logic [7:0]  skew;
      variant = $urandom_range(0, 99);
      q = '{};
      if (variant >= 93) begin
         repeat ($urandom_range(1, 8)) q.push_back(8'($urandom_range(0, 255)));
      end else begin
         case ($urandom_range(0, 2))
            0: nib = code_a;
            1: nib = code_b;
            default: nib = code_c;
         endcase
         if (variant >= 78 && variant < 83) begin
            do nib = 4'($urandom_range(0, 15));
            while (nib == code_a || nib == code_b || nib == code_c);
         end
         cap = len_limit - 16'd1;
         if ($urandom_range(0, 19) != 0) cap = (cap > 16'd40) ? 16'd40 : cap;
         else cap = (cap > 16'd600) ? 16'd600 : cap;
         length = 16'($urandom_range(0, cap));
         if (variant >= 83 && variant < 88) length = 16'($urandom_range(65535, len_limit));
         skew = 8'h00;
         if (variant >= 88 && variant < 93) skew = 8'($urandom_range(1, 255));
         q = build_header({nib, 4'($urandom_range(0, 15))}, length, skew);
         if (variant < 78) begin
            for (i = 0; i < length; i++) q.push_back(8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(0, 3)) q.push_back(8'($urandom_range(0, 255)));
         end
         // trailing bytes after the frame
         if (variant >= 60 && variant < 70)
            repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(0, 255)));
         // early buffer end anywhere in the frame
         if (variant >= 70 && variant < 78) begin
            cut = $urandom_range(1, q.size());
            while (q.size() > cut) void'(q.pop_back());
         end
      end
      send_buffer(q);
   endtask

   // random traffic under several settings, last one without idling
   task automatic test_random_traffic();
      int stage;
      int start_count;
      for (stage = 0; stage < 4; stage++) begin
         case (stage)
            0: apply_setting(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                             4'($urandom_range(0, 15)), 16'($urandom_range(601, 65535)));
            1: apply_setting(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                             4'($urandom_range(0, 15)), 16'($urandom_range(1, 12)));
            2: apply_setting(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                             4'($urandom_range(0, 15)), 16'd65535);
            default: begin
               apply_setting(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                             4'($urandom_range(0, 15)), 16'd4096);
               idle_enable = 1'b0;
            end
         endcase
         start_count = bytes_sent;
         while (bytes_sent - start_count < 300) send_random_buffer();
      end
   endtask

   // main sequence
   initial begin
      int wait_cycles;
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.data_byte  = 8'h00;
      req_chan.buffer_end = 1'b0;
      psel                = 1'b0;
      penable             = 1'b0;
      pwrite              = 1'b0;
      paddr               = '0;
      pwdata              = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_directed_frames();
      test_register_extremes();
      test_random_traffic();

      req_chan.valid <= 1'b0;
      for (wait_cycles = 0; pending_results.size() != 0 && wait_cycles < 100000;
           wait_cycles++)
         @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch($sformatf("%0d expected results never came",
                                   pending_results.size()));
      repeat (8) @(posedge clock);
      $display("sent %0d input bytes, checked %0d results under %0d register settings",
               bytes_sent, results_checked, settings_applied);
      $display("mismatches counted: %0d", error_count);
      if (error_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
